[rtl/nfsp_pkg.sv]
// Shared types, character codes and event/status codes for the newline
// framed status parser. No dependencies.
package nfsp_pkg;

  localparam int unsigned PayloadLimitDefault = 128;
  localparam int unsigned StaleResetMs        = 1000;

  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChTilde   = 8'h7E;
  localparam logic [7:0] ChBang    = 8'h21;
  localparam logic [7:0] ChDollar  = 8'h24;
  localparam logic [7:0] ChComma   = 8'h2C;
  localparam logic [7:0] Ch0       = 8'h30;
  localparam logic [7:0] Ch1       = 8'h31;
  localparam logic [7:0] Ch2       = 8'h32;
  localparam logic [7:0] Ch7       = 8'h37;
  localparam logic [7:0] Ch9       = 8'h39;
  localparam logic [7:0] ChA       = 8'h41;
  localparam logic [7:0] ChO       = 8'h4F;
  localparam logic [7:0] ChS       = 8'h53;

  typedef enum logic [2:0] {
    EvNone     = 3'd0,
    EvStorage  = 3'd1,
    EvOverflow = 3'd2,
    EvSensor   = 3'd3,
    EvError    = 3'd4
  } nfsp_event_e;

  typedef enum logic [2:0] {
    StWaiting  = 3'd0,
    StStale    = 3'd1,
    StDisabled = 3'd2,
    StOk       = 3'd3,
    StFault    = 3'd4
  } nfsp_stor_e;

  // Table writes decided by one line verdict
  typedef struct packed {
    logic        stor_we;
    logic        stor_idx;
    logic [1:0]  stor_mode;
    logic        ovf_we;
    logic        sens_we;
    logic [2:0]  sens_idx;   // sensor number 1..7
    logic [31:0] number;
    logic [31:0] stamp;
  } nfsp_upd_t;

endpackage

[rtl/nfsp_line_parser.sv]
// Line framing, head capture, decimal accumulation, payload echo and line verdict.
// Depends on nfsp_pkg.
module nfsp_line_parser
  import nfsp_pkg::*;
#(
  parameter int unsigned PayloadLimit = PayloadLimitDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  input  logic [31:0] now_i,
  output nfsp_event_e event_o,
  output logic [2:0]  id_o,
  output logic [7:0]  payload_byte_o,
  output logic        payload_valid_o,
  output logic [31:0] error_count_o,
  output nfsp_upd_t   upd_o
);

  localparam int unsigned LineMax = PayloadLimit + 7;
  localparam int unsigned LenW    = $clog2(LineMax + 1);

  logic [LenW-1:0] len_q, len_d;
  logic            disc_q, disc_d;
  logic [7:0]      head_q [7];
  logic [7:0]      head_d [7];
  logic [31:0]     acc_q, acc_d;
  logic            bad_q, bad_d;
  logic [31:0]     err_q, err_d;

  logic            is_nl, printable, full, is_digit;
  logic [LenW-1:0] new_len;
  logic [7:0]      head_n [7];
  logic [35:0]     acc_wide;
  logic            pref_s_n, pref_o_n, pref_a_n, sens_ok_n, do_acc, echo;
  logic            pref_s, pref_o, pref_a, stor_ok, ovf_match, sens_ok;

  assign is_nl     = byte_i == ChNewline;
  assign printable = (byte_i >= ChSpace) && (byte_i <= ChTilde);
  assign full      = len_q == LenW'(LineMax);
  assign new_len   = len_q + LenW'(1);
  assign is_digit  = byte_i inside {[Ch0:Ch9]};
  // acc * 10 + digit, wide enough to see a 32-bit overflow
  assign acc_wide  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
                   + {32'd0, byte_i[3:0]};

  always_comb begin
    head_n = head_q;
    if (len_q < LenW'(7)) begin
      head_n[len_q[2:0]] = byte_i;
    end
  end

  // Head checks as seen after this byte is stored
  assign pref_s_n = (new_len >= LenW'(3)) && head_n[0] == ChBang && head_n[1] == ChS
                    && head_n[2] == ChComma;
  assign pref_o_n = (new_len >= LenW'(3)) && head_n[0] == ChBang && head_n[1] == ChO
                    && head_n[2] == ChComma;
  assign pref_a_n = (new_len >= LenW'(3)) && head_n[0] == ChBang && head_n[1] == ChA
                    && head_n[2] == ChComma;
  assign sens_ok_n = pref_a_n && (new_len >= LenW'(5)) && (head_n[3] inside {[Ch1:Ch7]})
                     && head_n[4] == ChComma;
  assign do_acc = (pref_s_n && len_q >= LenW'(7)) || (pref_o_n && len_q >= LenW'(5));
  assign echo   = (len_q >= LenW'(5)) && sens_ok_n && head_n[5] == ChDollar
                  && (new_len < LenW'(PayloadLimit + 5));

  // Verdict checks on the completed line
  assign pref_s = (len_q >= LenW'(3)) && head_q[0] == ChBang && head_q[1] == ChS
                  && head_q[2] == ChComma;
  assign pref_o = (len_q >= LenW'(3)) && head_q[0] == ChBang && head_q[1] == ChO
                  && head_q[2] == ChComma;
  assign pref_a = (len_q >= LenW'(3)) && head_q[0] == ChBang && head_q[1] == ChA
                  && head_q[2] == ChComma;
  assign stor_ok = (len_q >= LenW'(8)) && (head_q[3] inside {[Ch0:Ch1]})
                   && head_q[4] == ChComma && (head_q[5] inside {[Ch0:Ch2]})
                   && head_q[6] == ChComma && !bad_q;
  assign ovf_match = (len_q >= LenW'(6)) && pref_o && (head_q[3] inside {[Ch1:Ch7]})
                     && head_q[4] == ChComma;
  assign sens_ok = (len_q >= LenW'(7)) && pref_a && (head_q[3] inside {[Ch1:Ch7]})
                   && head_q[4] == ChComma && head_q[5] == ChDollar
                   && (len_q < LenW'(PayloadLimit + 5));

  always_comb begin
    len_d           = len_q;
    disc_d          = disc_q;
    head_d          = head_q;
    acc_d           = acc_q;
    bad_d           = bad_q;
    err_d           = err_q;
    event_o         = EvNone;
    id_o            = 3'd0;
    payload_byte_o  = 8'd0;
    payload_valid_o = 1'b0;
    upd_o           = '0;
    upd_o.number    = acc_q;
    upd_o.stamp     = now_i;
    upd_o.stor_idx  = head_q[3][0];
    upd_o.stor_mode = head_q[5][1:0];
    upd_o.sens_idx  = head_q[3][2:0];
    if (is_nl) begin
      if (!disc_q && len_q != '0) begin
        if (pref_s) begin
          if (stor_ok) begin
            upd_o.stor_we = 1'b1;
            event_o       = EvStorage;
            id_o          = {2'b00, head_q[3][0]};
          end else begin
            err_d   = err_q + 32'd1;
            event_o = EvError;
          end
        end else if (ovf_match) begin
          if (bad_q) begin
            err_d   = err_q + 32'd1;
            event_o = EvError;
          end else begin
            upd_o.ovf_we = 1'b1;
            event_o      = EvOverflow;
            id_o         = head_q[3][2:0];
          end
        end else if (sens_ok) begin
          upd_o.sens_we = 1'b1;
          event_o       = EvSensor;
          id_o          = head_q[3][2:0];
        end else begin
          err_d   = err_q + 32'd1;
          event_o = EvError;
        end
      end
      len_d  = '0;
      disc_d = 1'b0;
      acc_d  = 32'd0;
      bad_d  = 1'b0;
    end else if (!disc_q) begin
      if (!printable || full) begin
        err_d   = err_q + 32'd1;
        disc_d  = 1'b1;
        event_o = EvError;
      end else begin
        head_d = head_n;
        len_d  = new_len;
        if (len_q == '0) begin
          acc_d = 32'd0;
          bad_d = 1'b0;
        end
        if (do_acc && !bad_q) begin
          if (!is_digit || acc_wide[35:32] != 4'd0) begin
            bad_d = 1'b1;
          end else begin
            acc_d = acc_wide[31:0];
          end
        end
        if (echo) begin
          payload_byte_o  = byte_i;
          payload_valid_o = 1'b1;
          id_o            = head_n[3][2:0];
        end
      end
    end
  end

  assign error_count_o = err_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      disc_q <= 1'b1;
      acc_q  <= 32'd0;
      bad_q  <= 1'b0;
      err_q  <= 32'd0;
    end else if (step_i) begin
      len_q  <= len_d;
      disc_q <= disc_d;
      acc_q  <= acc_d;
      bad_q  <= bad_d;
      err_q  <= err_d;
    end
  end

  // Head bytes are only read behind a length check
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      head_q <= head_d;
    end
  end

endmodule

[rtl/nfsp_status_tables.sv]
// Per-sensor and per-storage status tables with post-update query read and
// storage staleness. Depends on nfsp_pkg.
module nfsp_status_tables
  import nfsp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  nfsp_upd_t   upd_i,
  input  logic [31:0] now_i,
  input  logic [2:0]  query_sensor_i,
  input  logic        query_storage_i,
  input  logic [32:0] limit3_i,
  output logic        queried_seen_o,
  output logic [31:0] queried_last_ms_o,
  output logic [31:0] queried_overflows_o,
  output nfsp_stor_e  storage_state_o,
  output logic [31:0] storage_error_count_o
);

  logic        sens_seen_q [7];
  logic        sens_seen_d [7];
  logic [31:0] sens_time_q [7];
  logic [31:0] sens_time_d [7];
  logic [31:0] sens_ovf_q  [7];
  logic [31:0] sens_ovf_d  [7];
  logic        stor_seen_q [2];
  logic        stor_seen_d [2];
  logic [1:0]  stor_mode_q [2];
  logic [1:0]  stor_mode_d [2];
  logic [31:0] stor_err_q  [2];
  logic [31:0] stor_err_d  [2];
  logic [31:0] stor_time_q [2];
  logic [31:0] stor_time_d [2];

  logic [2:0]  wr_n, rd_n;
  logic [31:0] age;

  assign wr_n = upd_i.sens_idx - 3'd1;
  assign rd_n = query_sensor_i - 3'd1;

  always_comb begin
    sens_seen_d = sens_seen_q;
    sens_time_d = sens_time_q;
    sens_ovf_d  = sens_ovf_q;
    stor_seen_d = stor_seen_q;
    stor_mode_d = stor_mode_q;
    stor_err_d  = stor_err_q;
    stor_time_d = stor_time_q;
    if (step_i && upd_i.sens_we) begin
      sens_seen_d[wr_n] = 1'b1;
      sens_time_d[wr_n] = upd_i.stamp;
    end
    if (step_i && upd_i.ovf_we) begin
      sens_ovf_d[wr_n] = upd_i.number;
    end
    if (step_i && upd_i.stor_we) begin
      stor_seen_d[upd_i.stor_idx] = 1'b1;
      stor_mode_d[upd_i.stor_idx] = upd_i.stor_mode;
      stor_err_d[upd_i.stor_idx]  = upd_i.number;
      stor_time_d[upd_i.stor_idx] = upd_i.stamp;
    end
  end

  // Query reads see this item's own update
  always_comb begin
    if (query_sensor_i == 3'd0) begin
      queried_seen_o      = 1'b0;
      queried_last_ms_o   = 32'd0;
      queried_overflows_o = 32'd0;
    end else begin
      queried_seen_o      = sens_seen_d[rd_n];
      queried_last_ms_o   = sens_time_d[rd_n];
      queried_overflows_o = sens_ovf_d[rd_n];
    end
  end

  assign age                   = now_i - stor_time_d[query_storage_i];
  assign storage_error_count_o = stor_err_d[query_storage_i];

  always_comb begin
    if (!stor_seen_d[query_storage_i]) begin
      storage_state_o = ({1'b0, now_i} > limit3_i) ? StStale : StWaiting;
    end else if ({1'b0, age} > limit3_i) begin
      storage_state_o = StStale;
    end else begin
      case (stor_mode_d[query_storage_i])
        2'd0:    storage_state_o = StDisabled;
        2'd1:    storage_state_o = StOk;
        default: storage_state_o = StFault;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 7; i++) begin
        sens_seen_q[i] <= 1'b0;
        sens_time_q[i] <= 32'd0;
        sens_ovf_q[i]  <= 32'd0;
      end
      for (int i = 0; i < 2; i++) begin
        stor_seen_q[i] <= 1'b0;
        stor_mode_q[i] <= 2'd0;
        stor_err_q[i]  <= 32'd0;
        stor_time_q[i] <= 32'd0;
      end
    end else begin
      sens_seen_q <= sens_seen_d;
      sens_time_q <= sens_time_d;
      sens_ovf_q  <= sens_ovf_d;
      stor_seen_q <= stor_seen_d;
      stor_mode_q <= stor_mode_d;
      stor_err_q  <= stor_err_d;
      stor_time_q <= stor_time_d;
    end
  end

endmodule

[rtl/newline_frame_status_parser.sv]
// Top level of the newline framed status parser: input register, parser,
// status tables and result register. Depends on nfsp_pkg and both submodules.
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid/s_tready    tdata: rx_byte, now_ms; tuser: query fields
//  m_*      out  m_tvalid/m_tready    tdata: report fields; tuser: event, echo flag
//  cfg_*    in   cfg_we               cfg_wdata: stale_period_ms
//
// One item per cycle sustained while m_tready is high; an item waits in the
// input register until the result register can take it, and its result is
// then written there. All per-item work is one combinational pass from the
// input register, through the parser and table update, into the result
// register. Reset clears tables and counters, loads a 1000 ms period and
// drops bytes up to the first newline. s_tready drops only while both
// registers are full and m_tready is low.
module newline_frame_status_parser
  import nfsp_pkg::*;
#(
  parameter int unsigned PayloadLimit = PayloadLimitDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  output logic         s_tready_o,
  input  logic [39:0]  s_tdata_i,  // [7:0] rx_byte, [39:8] now_ms
  input  logic [3:0]   s_tuser_i,  // [2:0] query_sensor, [3] query_storage
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  // [2:0] event_id, [10:3] payload_byte, [42:11] error_count, [43] queried_seen,
  // [75:44] queried_last_ms, [107:76] queried_overflows, [110:108] storage_state,
  // [142:111] storage_error_count, [143] zero
  output logic [143:0] m_tdata_o,
  output logic [3:0]   m_tuser_o,  // [2:0] event_res, [3] payload_valid
  input  logic         cfg_we_i,
  input  logic [30:0]  cfg_wdata_i
);

  logic        in_valid_q, in_valid_d;
  logic [7:0]  in_byte_q;
  logic [31:0] in_now_q;
  logic [2:0]  in_qs_q;
  logic        in_qst_q;
  logic        m_valid_q, m_valid_d;
  logic [143:0] m_data_q;
  logic [3:0]   m_user_q;
  logic [32:0]  limit3_q;

  logic        advance, s_take;
  nfsp_event_e ev;
  logic [2:0]  ev_id;
  logic [7:0]  pay_byte;
  logic        pay_valid;
  logic [31:0] err_count;
  nfsp_upd_t   upd;
  logic        q_seen;
  logic [31:0] q_last, q_ovf, stor_errs;
  nfsp_stor_e  stor_state;

  assign advance    = in_valid_q && (!m_valid_q || m_tready_i);
  assign s_tready_o = !in_valid_q || advance;
  assign s_take     = s_tvalid_i && s_tready_o;
  assign in_valid_d = s_take || (in_valid_q && !advance);
  assign m_valid_d  = advance || (m_valid_q && !m_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
      limit3_q   <= 33'(3 * StaleResetMs);
    end else begin
      in_valid_q <= in_valid_d;
      m_valid_q  <= m_valid_d;
      // hold three periods, no wrap
      if (cfg_we_i) begin
        limit3_q <= {2'b00, cfg_wdata_i} + {1'b0, cfg_wdata_i, 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_take) begin
      in_byte_q <= s_tdata_i[7:0];
      in_now_q  <= s_tdata_i[39:8];
      in_qs_q   <= s_tuser_i[2:0];
      in_qst_q  <= s_tuser_i[3];
    end
    if (advance) begin
      m_data_q <= {1'b0, stor_errs, stor_state, q_ovf, q_last, q_seen, err_count,
                   pay_byte, ev_id};
      m_user_q <= {pay_valid, ev};
    end
  end

  nfsp_line_parser #(
    .PayloadLimit(PayloadLimit)
  ) u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .byte_i         (in_byte_q),
    .now_i          (in_now_q),
    .event_o        (ev),
    .id_o           (ev_id),
    .payload_byte_o (pay_byte),
    .payload_valid_o(pay_valid),
    .error_count_o  (err_count),
    .upd_o          (upd)
  );

  nfsp_status_tables u_tables (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .step_i               (advance),
    .upd_i                (upd),
    .now_i                (in_now_q),
    .query_sensor_i       (in_qs_q),
    .query_storage_i      (in_qst_q),
    .limit3_i             (limit3_q),
    .queried_seen_o       (q_seen),
    .queried_last_ms_o    (q_last),
    .queried_overflows_o  (q_ovf),
    .storage_state_o      (stor_state),
    .storage_error_count_o(stor_errs)
  );

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;
  assign m_tuser_o  = m_user_q;

`ifndef NO_ASSERTIONS
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_byte_q) && $stable(in_now_q))
    else $error("held input item changed or vanished");

  a_adv_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_valid_q)
    else $error("processed item produced no result");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_tready_o |-> in_valid_q && m_valid_q && !m_tready_i)
    else $error("input stalled without a full pipeline");

  a_event_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> m_user_q[2:0] <= EvError)
    else $error("result carries an undefined event code");
`endif

endmodule
